// ===== hw/rtl/tdrp_pkg.sv =====
// Shared types and constants of the telemetry delta record packer.
`default_nettype none
package tdrp_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 512;
   localparam logic [7:0] GPS_DIVIDER_RESET = 8'd100;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [7:0] ID_TIME_ABS = 8'h01;
   localparam logic [7:0] ID_TIME_REL = 8'h02;
   localparam logic [7:0] ID_GPS_ABS  = 8'h03;
   localparam logic [7:0] ID_GPS_DLT  = 8'h04;

   localparam int HDR_LEN      = 4;
   localparam int TIME_ABS_LEN = 5;
   localparam int TIME_REL_LEN = 2;
   localparam int GPS_ABS_LEN  = 28;
   localparam int GPS_DLT_LEN  = 14;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HDR, ST_PAD_T, ST_TIME, ST_PAD_G, ST_GPS, ST_ENDP
   } back_state_type;

   // one accepted item, classified and with all record bytes prepared
   typedef struct packed {
      logic              is_start;
      logic              is_end;
      logic              pad_t;
      logic              time_abs;
      logic              has_gps;
      logic              pad_g;
      logic              dlt_rec;
      logic [4:0][7:0]   time_bytes;
      logic [27:0][7:0]  gps_bytes;
      logic [31:0]       flight;
      logic [31:0]       blk;
      logic [8:0]        pos;
   } plan_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tdrp_front.sv =====
// Front end: accepts items, keeps flight state, plans the records of each item.
`default_nettype none
module tdrp_front #(
   parameter int BLOCK_BYTES = tdrp_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [7:0]        csr_write_data,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_operation,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic [31:0]       req_gps_time,
   input  wire logic signed [31:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic signed [31:0] req_ground_speed,
   input  wire logic signed [31:0] req_altitude,
   input  wire logic signed [31:0] req_heading,
   input  wire logic signed [7:0] req_satellites,
   input  wire logic [31:0]       req_flight_number,
   input  wire logic [31:0]       req_first_block,
   input  wire logic              q_full,
   output      logic              q_push,
   output      tdrp_pkg::plan_type q_plan
);
   import tdrp_pkg::*;

   localparam int POS_W = $clog2(BLOCK_BYTES) + 1;
   localparam logic [POS_W:0] LIMIT  = (POS_W+1)'(BLOCK_BYTES);
   localparam logic [POS_W:0] L_HDR  = (POS_W+1)'(HDR_LEN);
   localparam logic [POS_W:0] L_TABS = (POS_W+1)'(TIME_ABS_LEN);
   localparam logic [POS_W:0] L_TREL = (POS_W+1)'(TIME_REL_LEN);
   localparam logic [POS_W:0] L_GABS = (POS_W+1)'(GPS_ABS_LEN);
   localparam logic [POS_W:0] L_GDLT = (POS_W+1)'(GPS_DLT_LEN);

   logic              active_ff, active_in;
   logic [POS_W-1:0]  wpos_ff, wpos_in;
   logic [31:0]       blk_ff, blk_in;
   logic [31:0]       flight_ff, flight_in;
   logic [31:0]       ptime_ff, ptime_in;
   logic [7:0]        tick_ff, tick_in;
   logic [7:0]        div_ff, div_in;
   logic [31:0]       pgt_ff, pgt_in;
   logic [4:0][31:0]  pvals_ff, pvals_in;
   logic [7:0]        psats_ff, psats_in;

   logic              accept, is_start, is_run, is_end;
   logic [31:0]       gap, tgap, blk_base;
   logic              time_abs, do_gps, use_delta, pad_t, pad_g;
   logic [POS_W:0]    tsize, gsize, pos_t, p1, p2;
   logic [4:0][31:0]  vals;
   logic signed [32:0] diff [5];
   logic [7:0]        sats_u;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_operation == OP_START);
   assign is_run    = (req_operation == OP_RUN) && active_ff;
   assign is_end    = (req_operation == OP_END) && active_ff;
   assign q_push    = accept && (is_start || is_run || is_end);
   assign sats_u    = req_satellites;

   always_comb begin
      vals = {req_heading, req_altitude, req_ground_speed, req_longitude, req_latitude};
      gap = req_now_ms - ptime_ff;
      time_abs = |gap[31:8];
      tsize = time_abs ? L_TABS : L_TREL;
      pos_t = is_start ? L_HDR : {1'b0, wpos_ff};
      pad_t = !is_start && (pos_t + tsize > LIMIT);
      p1 = (pad_t ? L_HDR : pos_t) + tsize;

      tgap = req_gps_time - pgt_ff;
      use_delta = !is_start && !(|tgap[31:8]);
      for (int i = 0; i < 5; i++) begin
         diff[i] = $signed({vals[i][31], vals[i]}) - $signed({pvals_ff[i][31], pvals_ff[i]});
         // fits int16 when bits 32..15 are all equal
         if (!((&diff[i][32:15]) || !(|diff[i][32:15]))) begin
            use_delta = 1'b0;
         end
      end
      do_gps = is_start || (tick_ff >= div_ff);
      gsize = use_delta ? L_GDLT : L_GABS;
      pad_g = !is_start && (p1 + gsize > LIMIT);
      p2 = (pad_g ? L_HDR : p1) + gsize;
      blk_base = is_start ? req_first_block : blk_ff;

      q_plan = '0;
      q_plan.is_start  = is_start;
      q_plan.is_end    = (req_operation == OP_END);
      q_plan.pad_t     = pad_t;
      q_plan.time_abs  = time_abs;
      q_plan.has_gps   = do_gps;
      q_plan.pad_g     = pad_g;
      q_plan.dlt_rec   = use_delta;
      q_plan.flight    = is_start ? req_flight_number : flight_ff;
      q_plan.blk       = blk_base;
      q_plan.pos       = is_start ? 9'd0 : 9'(wpos_ff);
      if (time_abs) begin
         q_plan.time_bytes = {req_now_ms, ID_TIME_ABS};
      end else begin
         q_plan.time_bytes = {24'd0, gap[7:0], ID_TIME_REL};
      end
      if (use_delta) begin
         q_plan.gps_bytes[0] = ID_GPS_DLT;
         q_plan.gps_bytes[1] = sats_u - psats_ff;
         q_plan.gps_bytes[2] = tgap[7:0];
         for (int i = 0; i < 5; i++) begin
            q_plan.gps_bytes[4+2*i] = diff[i][7:0];
            q_plan.gps_bytes[5+2*i] = diff[i][15:8];
         end
      end else begin
         q_plan.gps_bytes[0] = ID_GPS_ABS;
         q_plan.gps_bytes[1] = sats_u;
         for (int b = 0; b < 4; b++) begin
            q_plan.gps_bytes[4+b] = req_gps_time[8*b +: 8];
         end
         for (int i = 0; i < 5; i++) begin
            for (int b = 0; b < 4; b++) begin
               q_plan.gps_bytes[8+4*i+b] = vals[i][8*b +: 8];
            end
         end
      end

      active_in = active_ff;
      wpos_in   = wpos_ff;
      blk_in    = blk_ff;
      flight_in = flight_ff;
      ptime_in  = ptime_ff;
      tick_in   = tick_ff;
      pgt_in    = pgt_ff;
      pvals_in  = pvals_ff;
      psats_in  = psats_ff;
      div_in    = csr_write_enable ? csr_write_data : div_ff;
      if (accept && (is_start || is_run)) begin
         wpos_in  = do_gps ? p2[POS_W-1:0] : p1[POS_W-1:0];
         blk_in   = blk_base + 32'(pad_t) + 32'(do_gps && pad_g);
         ptime_in = req_now_ms;
         if (do_gps) begin
            pgt_in   = req_gps_time;
            pvals_in = vals;
            psats_in = sats_u;
         end
      end
      if (accept && is_start) begin
         active_in = 1'b1;
         flight_in = req_flight_number;
      end
      if (accept && is_run) begin
         tick_in = do_gps ? 8'd1 : tick_ff + 8'd1;
      end
      if (accept && is_end) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         wpos_ff   <= '0;
         blk_ff    <= '0;
         flight_ff <= '0;
         ptime_ff  <= '0;
         tick_ff   <= '0;
         div_ff    <= GPS_DIVIDER_RESET;
         pgt_ff    <= '0;
         pvals_ff  <= '0;
         psats_ff  <= '0;
      end else begin
         active_ff <= active_in;
         wpos_ff   <= wpos_in;
         blk_ff    <= blk_in;
         flight_ff <= flight_in;
         ptime_ff  <= ptime_in;
         tick_ff   <= tick_in;
         div_ff    <= div_in;
         pgt_ff    <= pgt_in;
         pvals_ff  <= pvals_in;
         psats_ff  <= psats_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tdrp_queue.sv =====
// Two-entry queue of planned items between front and back end.
`default_nettype none
module tdrp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tdrp_pkg::plan_type push_plan,
   output      logic              full,
   input  wire logic              pop,
   output      logic              not_empty,
   output      tdrp_pkg::plan_type head_plan
);
   import tdrp_pkg::*;

   plan_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_plan = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tdrp_back.sv =====
// Back end: walks a planned item and emits one byte or pad result per cycle while the output is free.
`default_nettype none
module tdrp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_not_empty,
   input  wire tdrp_pkg::plan_type q_plan,
   output      logic              q_pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_byte_value,
   output      logic [8:0]        rsp_byte_offset,
   output      logic [31:0]       rsp_block_index,
   output      logic              rsp_pad_commit,
   output      logic              rsp_last
);
   import tdrp_pkg::*;

   localparam logic [4:0] HDR_LAST  = 5'(HDR_LEN - 1);
   localparam logic [4:0] TABS_LAST = 5'(TIME_ABS_LEN - 1);
   localparam logic [4:0] TREL_LAST = 5'(TIME_REL_LEN - 1);
   localparam logic [4:0] GABS_LAST = 5'(GPS_ABS_LEN - 1);
   localparam logic [4:0] GDLT_LAST = 5'(GPS_DLT_LEN - 1);

   back_state_type state_ff, state_in;
   plan_type       plan_ff, plan_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [8:0]     pos_ff, pos_in;
   logic [31:0]    blk_ff, blk_in;
   logic           tdone_ff, tdone_in;
   logic           valid_ff, valid_in;
   logic [7:0]     val_ff, val_in;
   logic [8:0]     off_ff;
   logic [31:0]    oblk_ff;
   logic           pad_ff, pad_in;
   logic           last_ff, last_in;
   logic           out_free, emit;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      plan_in  = plan_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      blk_in   = blk_ff;
      tdone_in = tdone_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      val_in   = 8'd0;
      pad_in   = 1'b0;
      last_in  = 1'b0;
      if (state_ff == ST_IDLE) begin
         if (q_not_empty) begin
            q_pop    = 1'b1;
            plan_in  = q_plan;
            pos_in   = q_plan.pos;
            blk_in   = q_plan.blk;
            cnt_in   = '0;
            tdone_in = 1'b0;
            priority if (q_plan.is_start) state_in = ST_HDR;
            else if (q_plan.is_end)       state_in = ST_ENDP;
            else if (q_plan.pad_t)        state_in = ST_PAD_T;
            else                          state_in = ST_TIME;
         end
      end else if (out_free) begin
         emit = 1'b1;
         unique case (state_ff)
            ST_HDR: begin
               val_in = plan_ff.flight[8*cnt_ff[1:0] +: 8];
               pos_in = pos_ff + 9'd1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == HDR_LAST) begin
                  cnt_in   = '0;
                  state_in = tdone_ff ? ST_GPS : ST_TIME;
               end
            end
            ST_PAD_T, ST_PAD_G: begin
               pad_in   = 1'b1;
               pos_in   = '0;
               blk_in   = blk_ff + 32'd1;
               state_in = ST_HDR;
            end
            ST_TIME: begin
               val_in = plan_ff.time_bytes[cnt_ff[2:0]];
               pos_in = pos_ff + 9'd1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == (plan_ff.time_abs ? TABS_LAST : TREL_LAST)) begin
                  cnt_in   = '0;
                  tdone_in = 1'b1;
                  last_in  = !plan_ff.has_gps;
                  if (!plan_ff.has_gps)  state_in = ST_IDLE;
                  else if (plan_ff.pad_g) state_in = ST_PAD_G;
                  else                    state_in = ST_GPS;
               end
            end
            ST_GPS: begin
               val_in = plan_ff.gps_bytes[cnt_ff];
               pos_in = pos_ff + 9'd1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == (plan_ff.dlt_rec ? GDLT_LAST : GABS_LAST)) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            ST_ENDP: begin
               pad_in   = 1'b1;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
            default: begin
               emit     = 1'b0;
               state_in = ST_IDLE;
            end
         endcase
      end
      valid_in = emit || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff  <= plan_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      blk_ff   <= blk_in;
      tdone_ff <= tdone_in;
      if (emit) begin
         val_ff  <= val_in;
         off_ff  <= pos_ff;
         oblk_ff <= blk_ff;
         pad_ff  <= pad_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_byte_value  = val_ff;
   assign rsp_byte_offset = off_ff;
   assign rsp_block_index = oblk_ff;
   assign rsp_pad_commit  = pad_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/telemetry_delta_record_packer_core.sv =====
// Top level of the telemetry delta record packer.
//
//  channel | direction | transfer on            | payload
//  req_    | in        | req_valid & req_ready  | operation, time, GPS sample, flight
//  rsp_    | out       | rsp_valid & rsp_ready  | byte, offset, block, pad_commit, last
//  csr_    | in        | csr_write_enable       | gps_divider
//
// An item is planned by the front end in the cycle it is accepted; the back end
// then loads it from the two-entry queue and emits one result per cycle while the
// output is free, up to 38 results per item. The back end byte walk sets the rate.
// Reset is synchronous; no clearing pass. req_ready drops only while the queue is
// full; a stalled rsp_ready holds the output register and backs up the queue.
`default_nettype none
module telemetry_delta_record_packer_core #(
   parameter int BLOCK_BYTES = tdrp_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [7:0]        csr_write_data,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_operation,
   input  wire logic [31:0]       req_now_ms,
   input  wire logic [31:0]       req_gps_time,
   input  wire logic signed [31:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic signed [31:0] req_ground_speed,
   input  wire logic signed [31:0] req_altitude,
   input  wire logic signed [31:0] req_heading,
   input  wire logic signed [7:0] req_satellites,
   input  wire logic [31:0]       req_flight_number,
   input  wire logic [31:0]       req_first_block,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_byte_value,
   output      logic [8:0]        rsp_byte_offset,
   output      logic [31:0]       rsp_block_index,
   output      logic              rsp_pad_commit,
   output      logic              rsp_last
);
   import tdrp_pkg::*;

   plan_type push_plan, head_plan;
   logic     q_full, q_push, q_pop, q_not_empty;

   tdrp_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_operation, .req_now_ms, .req_gps_time,
      .req_latitude, .req_longitude, .req_ground_speed, .req_altitude,
      .req_heading, .req_satellites, .req_flight_number, .req_first_block,
      .q_full, .q_push, .q_plan(push_plan)
   );

   tdrp_queue u_queue (
      .clock, .reset, .push(q_push), .push_plan, .full(q_full),
      .pop(q_pop), .not_empty(q_not_empty), .head_plan
   );

   tdrp_back u_back (
      .clock, .reset, .q_not_empty, .q_plan(head_plan), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_byte_value, .rsp_byte_offset,
      .rsp_block_index, .rsp_pad_commit, .rsp_last
   );

endmodule
`default_nettype wire

// ===== tb/telemetry_delta_record_packer_checker.sv =====
// Scoreboard for the telemetry packer: tracks state, predicts records, checks results.
`timescale 1ns / 1ps
module telemetry_delta_record_packer_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic [31:0]        req_gps_time,
   input  wire logic signed [31:0] req_latitude,
   input  wire logic signed [31:0] req_longitude,
   input  wire logic signed [31:0] req_ground_speed,
   input  wire logic signed [31:0] req_altitude,
   input  wire logic signed [31:0] req_heading,
   input  wire logic signed [7:0]  req_satellites,
   input  wire logic [31:0]        req_flight_number,
   input  wire logic [31:0]        req_first_block,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [7:0]         rsp_byte_value,
   input  wire logic [8:0]         rsp_byte_offset,
   input  wire logic [31:0]        rsp_block_index,
   input  wire logic               rsp_pad_commit,
   input  wire logic               rsp_last,
   output int                      error_count,
   output int                      pending
);
   import tdrp_pkg::*;

   typedef struct {
      logic [7:0]  value;
      logic [8:0]  offset;
      logic [31:0] blk;
      logic        pad;
      logic        last;
   } block_byte_type;

   block_byte_type block_bytes_q[$];

   logic [7:0]  gps_divider;
   logic        flying;
   int          wr_pos;
   logic [31:0] cur_block;
   logic [31:0] flight_id;
   logic [31:0] last_time_ms;
   logic [7:0]  tick_count;
   logic [31:0] last_gps_time;
   logic [31:0] last_gps_vals [5];
   logic [7:0]  last_sats;

   task automatic put_byte(input logic [7:0] b);
      block_bytes_q.push_back('{b, wr_pos[8:0], cur_block, 1'b0, 1'b0});
      wr_pos++;
   endtask

   task automatic put_word(input logic [31:0] w, input int nbytes);
      for (int i = 0; i < nbytes; i++) put_byte(w[8*i +: 8]);
   endtask

   task automatic put_pad();
      block_bytes_q.push_back('{8'h00, wr_pos[8:0], cur_block, 1'b1, 1'b0});
   endtask

   task automatic start_block();
      wr_pos = 0;
      put_word(flight_id, HDR_LEN);
   endtask

   // close the block first when the record would not fit
   task automatic reserve(input int len);
      if (wr_pos + len > BLOCK_BYTES_DEFAULT) begin
         put_pad();
         cur_block++;
         start_block();
      end
   endtask

   task automatic log_time(input logic [31:0] now);
      logic [31:0] gap;
      gap = now - last_time_ms;
      if (gap > 32'hFF) begin
         reserve(TIME_ABS_LEN);
         put_byte(ID_TIME_ABS);
         put_word(now, 4);
      end else begin
         reserve(TIME_REL_LEN);
         put_byte(ID_TIME_REL);
         put_byte(gap[7:0]);
      end
      last_time_ms = now;
   endtask

   task automatic log_position(input logic force_abs);
      logic [31:0] vals [5];
      longint      diffs [5];
      logic [31:0] tgap;
      logic        delta_ok;
      vals[0] = req_latitude;
      vals[1] = req_longitude;
      vals[2] = req_ground_speed;
      vals[3] = req_altitude;
      vals[4] = req_heading;
      tgap = req_gps_time - last_gps_time;
      delta_ok = !force_abs && tgap <= 32'hFF;
      for (int i = 0; i < 5; i++) begin
         diffs[i] = longint'($signed(vals[i])) - longint'($signed(last_gps_vals[i]));
         if (diffs[i] < -32768 || diffs[i] > 32767) delta_ok = 1'b0;
      end
      if (delta_ok) begin
         reserve(GPS_DLT_LEN);
         put_byte(ID_GPS_DLT);
         put_byte(req_satellites - last_sats);
         put_byte(tgap[7:0]);
         put_byte(8'h00);
         for (int i = 0; i < 5; i++) put_word({16'd0, diffs[i][15:0]}, 2);
      end else begin
         reserve(GPS_ABS_LEN);
         put_byte(ID_GPS_ABS);
         put_byte(req_satellites);
         put_byte(8'h00);
         put_byte(8'h00);
         put_word(req_gps_time, 4);
         for (int i = 0; i < 5; i++) put_word(vals[i], 4);
      end
      last_gps_time = req_gps_time;
      for (int i = 0; i < 5; i++) last_gps_vals[i] = vals[i];
      last_sats = req_satellites;
   endtask

   task automatic predict_item();
      int first;
      first = block_bytes_q.size();
      case (req_operation)
         OP_START: begin
            cur_block = req_first_block;
            flight_id = req_flight_number;
            start_block();
            log_time(req_now_ms);
            log_position(1'b1);
            flying = 1'b1;
         end
         OP_RUN: begin
            if (flying) begin
               log_time(req_now_ms);
               if (tick_count >= gps_divider) begin
                  log_position(1'b0);
                  tick_count = '0;
               end
               tick_count = tick_count + 8'd1;
            end
         end
         OP_END: begin
            if (flying) begin
               flying = 1'b0;
               put_pad();
            end
         end
         default: ;
      endcase
      if (block_bytes_q.size() > first) block_bytes_q[block_bytes_q.size() - 1].last = 1'b1;
   endtask

   task automatic flag(input string what, input block_byte_type want);
      if (error_count < 10) begin
         $display("%0t mismatch (%s): want val=%h off=%0d blk=%h pad=%b last=%b",
                  $realtime, what, want.value, want.offset, want.blk, want.pad, want.last);
         $display("   got val=%h off=%0d blk=%h pad=%b last=%b",
                  rsp_byte_value, rsp_byte_offset, rsp_block_index, rsp_pad_commit, rsp_last);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      block_byte_type want;
      if (reset) begin
         gps_divider = GPS_DIVIDER_RESET;
         flying = 1'b0;
         wr_pos = 0;
         cur_block = '0;
         flight_id = '0;
         last_time_ms = '0;
         tick_count = '0;
         last_gps_time = '0;
         for (int i = 0; i < 5; i++) last_gps_vals[i] = '0;
         last_sats = '0;
         block_bytes_q.delete();
      end else begin
         if (csr_write_enable) gps_divider = csr_write_data;
         if (req_valid && req_ready) predict_item();
         if (rsp_valid && rsp_ready) begin
            if (block_bytes_q.size() == 0) begin
               want = '{8'h00, 9'd0, 32'd0, 1'b0, 1'b0};
               flag("unexpected transaction", want);
            end else begin
               want = block_bytes_q.pop_front();
               if (rsp_byte_value !== want.value || rsp_byte_offset !== want.offset ||
                   rsp_block_index !== want.blk || rsp_pad_commit !== want.pad ||
                   rsp_last !== want.last)
                  flag("field", want);
            end
         end
      end
      pending = block_bytes_q.size();
   end

endmodule

// ===== tb/telemetry_delta_record_packer_core_tb.sv =====
// Testbench top for the telemetry packer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module telemetry_delta_record_packer_core_tb;
   import tdrp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] now_ms;
      logic [31:0] gps_time;
      logic [31:0] vals [5];
      logic [7:0]  sats;
      logic [31:0] flight;
      logic [31:0] first_block;
   } sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_gps_time = '0;
   logic signed [31:0] req_latitude = '0;
   logic signed [31:0] req_longitude = '0;
   logic signed [31:0] req_ground_speed = '0;
   logic signed [31:0] req_altitude = '0;
   logic signed [31:0] req_heading = '0;
   logic signed [7:0]  req_satellites = '0;
   logic [31:0] req_flight_number = '0;
   logic [31:0] req_first_block = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_byte_value;
   logic [8:0]  rsp_byte_offset;
   logic [31:0] rsp_block_index;
   logic        rsp_pad_commit;
   logic        rsp_last;

   int error_count;
   int pending;
   int send_idle_pct = 25;
   int recv_idle_pct = 62;
   logic hold_trigger = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   sample_type s;
   logic    flying;

   telemetry_delta_record_packer_core uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_now_ms(req_now_ms),
      .req_gps_time(req_gps_time), .req_latitude(req_latitude),
      .req_longitude(req_longitude), .req_ground_speed(req_ground_speed),
      .req_altitude(req_altitude), .req_heading(req_heading),
      .req_satellites(req_satellites), .req_flight_number(req_flight_number),
      .req_first_block(req_first_block),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_byte_value(rsp_byte_value), .rsp_byte_offset(rsp_byte_offset),
      .rsp_block_index(rsp_block_index), .rsp_pad_commit(rsp_pad_commit),
      .rsp_last(rsp_last)
   );

   telemetry_delta_record_packer_checker scoreboard (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_now_ms(req_now_ms),
      .req_gps_time(req_gps_time), .req_latitude(req_latitude),
      .req_longitude(req_longitude), .req_ground_speed(req_ground_speed),
      .req_altitude(req_altitude), .req_heading(req_heading),
      .req_satellites(req_satellites), .req_flight_number(req_flight_number),
      .req_first_block(req_first_block),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_byte_value(rsp_byte_value), .rsp_byte_offset(rsp_byte_offset),
      .rsp_block_index(rsp_block_index), .rsp_pad_commit(rsp_pad_commit),
      .rsp_last(rsp_last),
      .error_count(error_count), .pending(pending)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (hold_trigger && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[telemetry_delta_record_packer_core] ERROR");
         $finish;
      end
   end

   task automatic send(input sample_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= t.op;
      req_now_ms <= t.now_ms;
      req_gps_time <= t.gps_time;
      req_latitude <= t.vals[0];
      req_longitude <= t.vals[1];
      req_ground_speed <= t.vals[2];
      req_altitude <= t.vals[3];
      req_heading <= t.vals[4];
      req_satellites <= t.sats;
      req_flight_number <= t.flight;
      req_first_block <= t.first_block;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering, let results drain, then allow for items that produce nothing
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_divider(input logic [7:0] v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // next sample: mostly small steps so relative and delta records dominate
   task automatic step_sample(input logic [1:0] op);
      s.op = op;
      s.now_ms = ($urandom_range(99) < 85) ? s.now_ms + $urandom_range(255) : $urandom;
      if ($urandom_range(99) < 85) begin
         s.gps_time = s.gps_time + $urandom_range(255);
         for (int i = 0; i < 5; i++)
            s.vals[i] = ($urandom_range(99) < 95) ?
                        s.vals[i] + $urandom_range(65535) - 32768 : $urandom;
      end else begin
         s.gps_time = ($urandom_range(1)) ? s.gps_time + 256 + $urandom_range(1000) : $urandom;
         for (int i = 0; i < 5; i++) s.vals[i] = $urandom;
      end
      s.sats = 8'($urandom);
      s.flight = $urandom;
      s.first_block = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(2) : $urandom;
   endtask

   task automatic random_items(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (!flying || r < 3) begin
            step_sample(OP_START);
            flying = 1'b1;
         end else if (r < 6) begin
            step_sample(OP_END);
            flying = 1'b0;
         end else if (r < 8) begin
            step_sample(OP_UNUSED);
         end else begin
            step_sample(OP_RUN);
         end
         send(s);
      end
      step_sample(OP_END);
      send(s);
      flying = 1'b0;
   endtask

   initial begin
      s.op = OP_RUN;
      s.now_ms = '0;
      s.gps_time = '0;
      for (int i = 0; i < 5; i++) s.vals[i] = '0;
      s.sats = '0;
      s.flight = '0;
      s.first_block = '0;
      flying = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle block: run, end and unused code are all ignored
      s.op = OP_RUN;     send(s);
      s.op = OP_END;     send(s);
      s.op = OP_UNUSED;  send(s);
      // start at extremes, timestamp relative to zero
      s.op = OP_START;
      s.flight = 32'hFFFF_FFFF;
      s.first_block = 32'hFFFF_FFFF;
      s.gps_time = 32'hFFFF_FFFF;
      s.vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};
      s.sats = 8'h80;
      send(s);
      s.op = OP_RUN;
      s.now_ms = 32'd255;  send(s);
      s.now_ms = 32'd511;  send(s);
      set_divider(8'd1);
      s.now_ms = 32'd767;  send(s);
      // delta at the int16 edges, satellites wrapping, time gap wrapping past zero
      s.now_ms = 32'd767;
      s.gps_time = 32'd254;
      s.vals = '{32'h8000_7FFF, 32'h7FFF_7FFF, 32'hFFFF_7FFF, 32'hFFFF_8000, 32'h8000_0000};
      s.sats = 8'h7F;
      send(s);
      send(s);
      s.vals[0] = s.vals[0] + 32'd32768;
      send(s); send(s);
      s.gps_time = s.gps_time + 32'd256;
      send(s); send(s);
      s.now_ms = 32'hFFFF_FFFF;
      s.sats = 8'h00;
      send(s); send(s);
      s.op = OP_UNUSED;  send(s);
      // start while active drops the open block
      s.op = OP_START;
      s.flight = 32'h0;
      s.first_block = 32'h0;
      s.now_ms = 32'h0000_0100;
      send(s);
      s.op = OP_RUN;     send(s);
      s.op = OP_END;     send(s);
      s.op = OP_END;     send(s);

      set_divider(8'd0);
      random_items(90);

      send_idle_pct = 62;
      recv_idle_pct = 25;
      set_divider(8'd255);
      send_idle_pct = 0;
      hold_trigger <= 1'b1;
      random_items(40);
      send_idle_pct = 62;
      set_divider(8'd3);
      random_items(50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_divider(8'd1);
      random_items(90);

      settle();
      if (error_count == 0 && pending == 0) begin
         $display("[telemetry_delta_record_packer_core] OK");
      end else begin
         $display("[telemetry_delta_record_packer_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tdrp_pkg.sv
hw/rtl/tdrp_front.sv
hw/rtl/tdrp_queue.sv
hw/rtl/tdrp_back.sv
hw/rtl/telemetry_delta_record_packer_core.sv
tb/telemetry_delta_record_packer_checker.sv
tb/telemetry_delta_record_packer_core_tb.sv
